@@ src/vgm_command_stream_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the command stream parser
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VGM_COMMAND_STREAM_PARSER_DEFINES_SVH
`define VGM_COMMAND_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define VGM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define VGM_ASSERT_NEVER(lbl, cond, msg) \
    `VGM_ASSERT(lbl, !(cond), msg)
`else
`define VGM_ASSERT(lbl, prop, msg)
`define VGM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ src/vgm_pkg.sv @@
// ----------------------------------------------------------------------------
// vgm_pkg
// Shared types, codes and constants of the command stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgm_pkg;

    // PCM bank geometry
    localparam int BANK_BYTES = 65536;
    localparam int BANK_AW    = $clog2(BANK_BYTES);
    localparam int FILL_W     = BANK_AW + 1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    localparam int OUT_TDATA_W = 136;

    // start position
    localparam logic [31:0] CFG_RESET  = 32'd12;
    localparam logic [31:0] START_BIAS = 32'h34;
    localparam logic [31:0] START_ZERO = 32'h40;

    // opcodes
    localparam logic [7:0] OP_STEREO    = 8'h4F;
    localparam logic [7:0] OP_PSG       = 8'h50;
    localparam logic [7:0] OP_FM0       = 8'h52;
    localparam logic [7:0] OP_FM1       = 8'h53;
    localparam logic [7:0] OP_WAIT      = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
    localparam logic [7:0] OP_END       = 8'h66;
    localparam logic [7:0] OP_BLOCK     = 8'h67;
    localparam logic [7:0] OP_SEEK      = 8'hE0;
    localparam logic [7:0] BLOCK_MARK   = 8'h66;
    localparam logic [7:0] BLOCK_TYPE0  = 8'h00;
    localparam logic [3:0] NIB_SHORT_WAIT = 4'h7;
    localparam logic [3:0] NIB_PCM        = 4'h8;

    localparam logic [7:0]  STEREO_REG = 8'h06;
    localparam logic [7:0]  PCM_REG    = 8'h2A;
    localparam logic [15:0] WAIT_NTSC  = 16'd735;
    localparam logic [15:0] WAIT_PAL   = 16'd882;

    typedef enum logic [3:0] {
        KIND_STEREO = 4'd0,
        KIND_PSG    = 4'd1,
        KIND_FM0    = 4'd2,
        KIND_FM1    = 4'd3,
        KIND_PCM    = 4'd4,
        KIND_WAIT   = 4'd5,
        KIND_END    = 4'd6,
        KIND_BLOCK  = 4'd7,
        KIND_SEEK   = 4'd8,
        KIND_ERROR  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OPCODE    = 3'd1,
        ERR_MARK      = 3'd2,
        ERR_TYPE      = 3'd3,
        ERR_OVERFLOW  = 3'd4,
        ERR_PAST_BANK = 3'd5
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [15:0] wait_samples;
        logic [31:0] bank_offset;
        logic [31:0] cmd_position;
        logic [31:0] cmd_index;
        err_t        error_code;
    } res_t;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         data;
    } bank_wr_t;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
    } bank_rd_t;

    // stream position of the first command byte
    function automatic logic [31:0] start_pos(input logic [31:0] field);
        start_pos = (field == 32'd0) ? START_ZERO : field + START_BIAS;
    endfunction

    // operand bytes that follow an opcode
    function automatic logic [2:0] operands_needed(input logic [7:0] op);
        if (op == OP_STEREO || op == OP_PSG)
            operands_needed = 3'd1;
        else if (op == OP_SEEK)
            operands_needed = 3'd4;
        else
            operands_needed = 3'd2;
    endfunction

endpackage

@@ src/vgm_ram.sv @@
// ----------------------------------------------------------------------------
// vgm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/vgm_parse.sv @@
// ----------------------------------------------------------------------------
// vgm_parse
// Parser state and decode: one stream byte per cycle, at most one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgm_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_data,
    output logic             res_valid,
    output vgm_pkg::res_t    res,
    output logic             pcm_hit,
    output vgm_pkg::bank_wr_t bank_wr,
    output vgm_pkg::bank_rd_t bank_rd
);

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_OPERANDS,
        PH_MARK,
        PH_TYPE,
        PH_SIZE,
        PH_DATA
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  held_opcode_reg, held_opcode_next;
    logic [2:0]                  operand_count_reg, operand_count_next;
    logic [31:0]                 operand_shift_reg, operand_shift_next;
    logic [31:0]                 block_remaining_reg, block_remaining_next;
    logic [vgm_pkg::FILL_W-1:0]  bank_fill_reg, bank_fill_next;
    logic                        overflow_reg, overflow_next;
    logic [31:0]                 seek_base_reg, seek_base_next;
    logic [31:0]                 read_pointer_reg, read_pointer_next;
    logic [31:0]                 stream_position_reg, stream_position_next;
    logic [31:0]                 command_total_reg, command_total_next;
    logic [31:0]                 start_of_command_reg, start_of_command_next;

    logic [31:0] shift_new;
    logic [2:0]  count_new;
    logic [31:0] pcm_addr;
    logic [31:0] fill_ext;
    logic        emit;
    logic        counted;
    vgm_pkg::kind_t kind_w;
    vgm_pkg::err_t  err_w;
    logic [7:0]  addr_w;
    logic [7:0]  value_w;
    logic [15:0] wait_w;

    // operand assembly, little endian
    assign shift_new = operand_shift_reg
                     | ({24'd0, byte_data} << {operand_count_reg[1:0], 3'b000});
    assign count_new = operand_count_reg + 3'd1;
    assign pcm_addr  = seek_base_reg + read_pointer_reg;
    assign fill_ext  = {{(32 - vgm_pkg::FILL_W){1'b0}}, bank_fill_reg};

    // next state and result
    always_comb
    begin
        phase_next           = phase_reg;
        held_opcode_next     = held_opcode_reg;
        operand_count_next   = operand_count_reg;
        operand_shift_next   = operand_shift_reg;
        block_remaining_next = block_remaining_reg;
        bank_fill_next       = bank_fill_reg;
        overflow_next        = overflow_reg;
        seek_base_next       = seek_base_reg;
        read_pointer_next    = read_pointer_reg;
        stream_position_next = stream_position_reg;
        start_of_command_next = start_of_command_reg;

        emit    = 1'b0;
        counted = 1'b0;
        kind_w  = vgm_pkg::KIND_ERROR;
        err_w   = vgm_pkg::ERR_NONE;
        addr_w  = 8'd0;
        value_w = 8'd0;
        wait_w  = 16'd0;
        pcm_hit = 1'b0;

        bank_wr = '0;
        bank_rd = '0;

        if (byte_valid)
        begin
            stream_position_next = stream_position_reg + 32'd1;
            unique case (phase_reg)
                PH_OPERANDS:
                begin
                    operand_shift_next = shift_new;
                    operand_count_next = count_new;
                    if (count_new >= vgm_pkg::operands_needed(held_opcode_reg))
                    begin
                        phase_next = PH_AWAIT;
                        emit       = 1'b1;
                        counted    = 1'b1;
                        unique case (held_opcode_reg)
                            vgm_pkg::OP_STEREO:
                            begin
                                kind_w  = vgm_pkg::KIND_STEREO;
                                addr_w  = vgm_pkg::STEREO_REG;
                                value_w = shift_new[7:0];
                            end
                            vgm_pkg::OP_PSG:
                            begin
                                kind_w  = vgm_pkg::KIND_PSG;
                                value_w = shift_new[7:0];
                            end
                            vgm_pkg::OP_FM0:
                            begin
                                kind_w  = vgm_pkg::KIND_FM0;
                                addr_w  = shift_new[7:0];
                                value_w = shift_new[15:8];
                            end
                            vgm_pkg::OP_FM1:
                            begin
                                kind_w  = vgm_pkg::KIND_FM1;
                                addr_w  = shift_new[7:0];
                                value_w = shift_new[15:8];
                            end
                            vgm_pkg::OP_WAIT:
                            begin
                                kind_w = vgm_pkg::KIND_WAIT;
                                wait_w = shift_new[15:0];
                            end
                            default:
                            begin
                                // seek
                                kind_w            = vgm_pkg::KIND_SEEK;
                                seek_base_next    = shift_new;
                                read_pointer_next = 32'd0;
                            end
                        endcase
                    end
                end
                PH_MARK:
                begin
                    if (byte_data != vgm_pkg::BLOCK_MARK)
                    begin
                        phase_next = PH_AWAIT;
                        emit       = 1'b1;
                        err_w      = vgm_pkg::ERR_MARK;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (byte_data != vgm_pkg::BLOCK_TYPE0)
                    begin
                        phase_next = PH_AWAIT;
                        emit       = 1'b1;
                        err_w      = vgm_pkg::ERR_TYPE;
                    end
                    else
                    begin
                        phase_next         = PH_SIZE;
                        operand_count_next = 3'd0;
                        operand_shift_next = 32'd0;
                    end
                end
                PH_SIZE:
                begin
                    operand_shift_next = shift_new;
                    operand_count_next = count_new;
                    if (count_new >= 3'd4)
                    begin
                        block_remaining_next = shift_new;
                        bank_fill_next       = '0;
                        overflow_next        = 1'b0;
                        if (shift_new == 32'd0)
                        begin
                            // empty block completes at once
                            phase_next        = PH_AWAIT;
                            seek_base_next    = 32'd0;
                            read_pointer_next = 32'd0;
                            emit              = 1'b1;
                            counted           = 1'b1;
                            kind_w            = vgm_pkg::KIND_BLOCK;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    // store while the bank has room, else drop and flag
                    if (!bank_fill_reg[vgm_pkg::BANK_AW])
                    begin
                        bank_wr.en     = 1'b1;
                        bank_wr.addr   = bank_fill_reg[vgm_pkg::BANK_AW-1:0];
                        bank_wr.data   = byte_data;
                        bank_fill_next = bank_fill_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    block_remaining_next = block_remaining_reg - 32'd1;
                    if (block_remaining_reg == 32'd1)
                    begin
                        phase_next        = PH_AWAIT;
                        seek_base_next    = 32'd0;
                        read_pointer_next = 32'd0;
                        emit              = 1'b1;
                        counted           = 1'b1;
                        kind_w            = vgm_pkg::KIND_BLOCK;
                        err_w = (overflow_reg || bank_fill_reg[vgm_pkg::BANK_AW])
                              ? vgm_pkg::ERR_OVERFLOW : vgm_pkg::ERR_NONE;
                    end
                end
                default:
                begin
                    // new opcode
                    phase_next            = PH_AWAIT;
                    start_of_command_next = stream_position_reg;
                    held_opcode_next      = byte_data;
                    operand_count_next    = 3'd0;
                    operand_shift_next    = 32'd0;
                    unique case (byte_data)
                        vgm_pkg::OP_STEREO, vgm_pkg::OP_PSG, vgm_pkg::OP_FM0,
                        vgm_pkg::OP_FM1, vgm_pkg::OP_WAIT, vgm_pkg::OP_SEEK:
                        begin
                            phase_next = PH_OPERANDS;
                        end
                        vgm_pkg::OP_BLOCK:
                        begin
                            phase_next = PH_MARK;
                        end
                        vgm_pkg::OP_WAIT_NTSC:
                        begin
                            emit    = 1'b1;
                            counted = 1'b1;
                            kind_w  = vgm_pkg::KIND_WAIT;
                            wait_w  = vgm_pkg::WAIT_NTSC;
                        end
                        vgm_pkg::OP_WAIT_PAL:
                        begin
                            emit    = 1'b1;
                            counted = 1'b1;
                            kind_w  = vgm_pkg::KIND_WAIT;
                            wait_w  = vgm_pkg::WAIT_PAL;
                        end
                        vgm_pkg::OP_END:
                        begin
                            emit    = 1'b1;
                            counted = 1'b1;
                            kind_w  = vgm_pkg::KIND_END;
                        end
                        default:
                        begin
                            emit = 1'b1;
                            priority if (byte_data[7:4] == vgm_pkg::NIB_SHORT_WAIT)
                            begin
                                counted = 1'b1;
                                kind_w  = vgm_pkg::KIND_WAIT;
                                wait_w  = {12'd0, byte_data[3:0]} + 16'd1;
                            end
                            else if (byte_data[7:4] == vgm_pkg::NIB_PCM)
                            begin
                                // bank byte arrives from the RAM next cycle
                                counted           = 1'b1;
                                kind_w            = vgm_pkg::KIND_PCM;
                                addr_w            = vgm_pkg::PCM_REG;
                                wait_w            = {12'd0, byte_data[3:0]};
                                read_pointer_next = read_pointer_reg + 32'd1;
                                if (pcm_addr < fill_ext)
                                begin
                                    pcm_hit      = 1'b1;
                                    bank_rd.en   = 1'b1;
                                    bank_rd.addr = pcm_addr[vgm_pkg::BANK_AW-1:0];
                                end
                                else
                                begin
                                    err_w = vgm_pkg::ERR_PAST_BANK;
                                end
                            end
                            else
                            begin
                                err_w = vgm_pkg::ERR_OPCODE;
                            end
                        end
                    endcase
                end
            endcase
        end

        // register write reloads the position
        if (cfg_we)
        begin
            stream_position_next = vgm_pkg::start_pos(cfg_data);
        end

        command_total_next = (emit && counted) ? command_total_reg + 32'd1
                                               : command_total_reg;

        res_valid          = emit;
        res.kind           = kind_w;
        res.reg_addr       = addr_w;
        res.reg_value      = value_w;
        res.wait_samples   = wait_w;
        res.bank_offset    = seek_base_next;
        res.cmd_position   = start_of_command_next;
        res.cmd_index      = command_total_reg;
        res.error_code     = err_w;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_AWAIT;
            held_opcode_reg      <= 8'd0;
            operand_count_reg    <= 3'd0;
            operand_shift_reg    <= 32'd0;
            block_remaining_reg  <= 32'd0;
            bank_fill_reg        <= '0;
            overflow_reg         <= 1'b0;
            seek_base_reg        <= 32'd0;
            read_pointer_reg     <= 32'd0;
            stream_position_reg  <= vgm_pkg::start_pos(vgm_pkg::CFG_RESET);
            command_total_reg    <= 32'd0;
            start_of_command_reg <= 32'd0;
        end
        else
        begin
            phase_reg            <= phase_next;
            held_opcode_reg      <= held_opcode_next;
            operand_count_reg    <= operand_count_next;
            operand_shift_reg    <= operand_shift_next;
            block_remaining_reg  <= block_remaining_next;
            bank_fill_reg        <= bank_fill_next;
            overflow_reg         <= overflow_next;
            seek_base_reg        <= seek_base_next;
            read_pointer_reg     <= read_pointer_next;
            stream_position_reg  <= stream_position_next;
            command_total_reg    <= command_total_next;
            start_of_command_reg <= start_of_command_next;
        end
    end

endmodule

@@ src/vgm_out_fifo.sv @@
// ----------------------------------------------------------------------------
// vgm_out_fifo
// Small register queue of decoded results ahead of the master port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgm_out_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  vgm_pkg::res_t             push_data,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output vgm_pkg::res_t             pop_data,
    output logic [vgm_pkg::CNT_W-1:0] count
);

    vgm_pkg::res_t                entry_reg [vgm_pkg::FIFO_DEPTH];
    logic [vgm_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vgm_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vgm_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{(vgm_pkg::CNT_W-1){1'b0}}, push}
                                - {{(vgm_pkg::CNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/vgm_command_stream_parser.sv @@
// ----------------------------------------------------------------------------
// vgm_command_stream_parser
// Music-log command stream parser: bytes in, decoded commands out.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while s_axis_tready is high and gives one
// decoded command per complete command. A byte passes an input register, then
// the parse logic, then a result register, and then reaches the four-entry
// result queue ahead of m_axis; s_axis_tready drops only when that queue and
// the two stages together hold four entries. PCM writes read the 64 KiB
// internal bank through its registered read port in the parse cycle, so the
// bank byte joins its result as it leaves the result register. The bank needs
// no clearing pass: reads only reach entries below the fill mark. The data
// offset register is taken at any time by cfg_valid and reloads the stream
// position; write it only while no bytes are in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vgm_command_stream_parser_defines.svh"

module vgm_command_stream_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    // stream_byte [7:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    // reg_addr [7:0], reg_value [15:8], wait_samples [31:16],
    // bank_offset [63:32], cmd_position [95:64], cmd_index [127:96],
    // error_code [130:128], zero fill [135:131]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [vgm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind [3:0]
    output logic [3:0]                      m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data
);

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s2_valid_reg;
    logic                       s2_hit_reg;
    vgm_pkg::res_t              s2_res_reg;

    logic                       res_valid;
    vgm_pkg::res_t              res;
    logic                       pcm_hit;
    vgm_pkg::bank_wr_t          bank_wr;
    vgm_pkg::bank_rd_t          bank_rd;
    logic [7:0]                 bank_rdata;
    vgm_pkg::res_t              push_data;
    vgm_pkg::res_t              out_res;
    logic [vgm_pkg::CNT_W-1:0]  fifo_count;
    logic [vgm_pkg::CNT_W:0]    occupancy;
    logic                       in_xfer;

    // credit: every entry in flight has a queue slot waiting
    assign occupancy = {1'b0, fifo_count}
                     + {{vgm_pkg::CNT_W{1'b0}}, s1_valid_reg}
                     + {{vgm_pkg::CNT_W{1'b0}}, s2_valid_reg};
    assign s_axis_tready = (occupancy < (vgm_pkg::CNT_W+1)'(vgm_pkg::FIFO_DEPTH));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= s_axis_tdata;
        end
    end

    vgm_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s1_valid_reg),
        .byte_data  (s1_byte_reg),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res        (res),
        .pcm_hit    (pcm_hit),
        .bank_wr    (bank_wr),
        .bank_rd    (bank_rd)
    );

    vgm_ram #(
        .WIDTH (8),
        .DEPTH (vgm_pkg::BANK_BYTES)
    ) u_bank (
        .clk   (clk),
        .we    (bank_wr.en),
        .waddr (bank_wr.addr),
        .wdata (bank_wr.data),
        .re    (bank_rd.en),
        .raddr (bank_rd.addr),
        .rdata (bank_rdata)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            s2_res_reg <= res;
            s2_hit_reg <= pcm_hit;
        end
    end

    // merge the bank byte into PCM results
    always_comb
    begin
        push_data = s2_res_reg;
        if (s2_hit_reg)
        begin
            push_data.reg_value = bank_rdata;
        end
    end

    vgm_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (out_res),
        .count     (fifo_count)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'd0, out_res.error_code, out_res.cmd_index,
                           out_res.cmd_position, out_res.bank_offset,
                           out_res.wait_samples, out_res.reg_value,
                           out_res.reg_addr};

    // checks
    `VGM_ASSERT_NEVER(a_queue_room, s2_valid_reg && (fifo_count == vgm_pkg::CNT_W'(vgm_pkg::FIFO_DEPTH)), "result pushed into a full queue")
    `VGM_ASSERT(a_result_source, s2_valid_reg |-> $past(s1_valid_reg), "result without a parsed byte")
    `VGM_ASSERT(a_bank_read_pcm, bank_rd.en |=> (s2_valid_reg && s2_hit_reg && s2_res_reg.kind == vgm_pkg::KIND_PCM), "bank read not matched by a PCM result")

endmodule
